@@ rtl/flow_feature_accumulator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the flow feature accumulator
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef FLOW_FEATURE_ACCUMULATOR_UNIT_MACROS_SVH
`define FLOW_FEATURE_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow feature accumulator package
// Field widths, function codes, sample set numbers and feature indexes.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int S_DATA_W = 80;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 72;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_EXPORT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam int NUM_SETS  = 6;
  localparam int NUM_SLOTS = 3;
  localparam int NUM_FLAGS = 6;

  localparam logic [2:0] SET_ALL_LEN = 3'd0;
  localparam logic [2:0] SET_ALL_IAT = 3'd1;
  localparam logic [2:0] SET_FWD_LEN = 3'd2;
  localparam logic [2:0] SET_BWD_LEN = 3'd3;
  localparam logic [2:0] SET_FWD_IAT = 3'd4;
  localparam logic [2:0] SET_BWD_IAT = 3'd5;

  localparam logic [1:0] SLOT_ALL = 2'd0;
  localparam logic [1:0] SLOT_FWD = 2'd1;
  localparam logic [1:0] SLOT_BWD = 2'd2;

  // flag byte bit for SYN ACK RST FIN PSH URG, in counter order
  localparam logic [2:0] FLAG_POS [NUM_FLAGS] = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd3, 3'd5};

  localparam logic [5:0] FEAT_DURATION  = 6'd0;
  localparam logic [5:0] FEAT_FWD_PKTS  = 6'd1;
  localparam logic [5:0] FEAT_BWD_PKTS  = 6'd2;
  localparam logic [5:0] FEAT_ALL_PKTS  = 6'd3;
  localparam logic [5:0] FEAT_FWD_BYTES = 6'd4;
  localparam logic [5:0] FEAT_BWD_BYTES = 6'd5;
  localparam logic [5:0] FEAT_SET0_BASE = 6'd6;
  localparam logic [5:0] FEAT_SET0_LAST = 6'd9;
  localparam logic [5:0] FEAT_BYTE_RATE = 6'd10;
  localparam logic [5:0] FEAT_PKT_RATE  = 6'd11;
  localparam logic [5:0] FEAT_FLAG_BASE = 6'd12;
  localparam logic [5:0] FEAT_FLAG_LAST = 6'd17;
  localparam logic [5:0] FEAT_SET1_BASE = 6'd18;
  localparam logic [5:0] LAST_FEATURE   = 6'd37;

  localparam logic [1:0] POS_MEAN = 2'd0;
  localparam logic [1:0] POS_STD  = 2'd1;
  localparam logic [1:0] POS_MIN  = 2'd2;
  localparam logic [1:0] POS_MAX  = 2'd3;

  localparam logic [62:0] OUT_MAX = '1;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } unit_op_t;

endpackage

@@ rtl/flow_feature_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// Flow feature accumulator
// Running statistics of one network flow and export of 38 feature words.
// ----------------------------------------------------------------------------
// Each input word is a packet update, an export request or a clear, and the
// block takes no new word until that one is finished. All divisions, products
// and square roots run one bit per cycle on a single shared add/subtract unit.
// A statistic update runs a quotient, then a product; a packet updates up to
// four statistics. An export streams 38 words: a plain feature is read out
// directly, a standard deviation needs a 64-step divide plus a 32-step root,
// and a rate a product, then a 64-step divide unless the product overflows.
// A clear returns the record to its empty state. Function code 3 is taken and
// dropped.
`include "flow_feature_accumulator_unit_macros.svh"

module flow_feature_accumulator_unit #(
  parameter int COUNT_BITS    = 32,
  parameter int TIME_BITS     = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // is_fwd, pkt_len[15:0], timestamp_us[47:0], flag_byte[7:0], zero pad
  input  logic [ffa_pkg::S_DATA_W-1:0] s_tdata,
  // func[1:0]
  input  logic [ffa_pkg::S_USER_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // feature_index[5:0], feature_value[62:0], zero pad
  output logic [ffa_pkg::M_DATA_W-1:0] m_tdata,
  // last_feature
  output logic                         m_tlast
);
  import ffa_pkg::*;

  // mean keeps 32 integer bits and FRACTION_BITS fraction bits
  localparam int MW      = 32 + FRACTION_BITS;
  localparam int MPAD    = 64 - MW;
  // product of two fixed deviations back to integer units squared
  localparam int INC_SH  = 32 + FRACTION_BITS;
  // rate scale 10^6 * 2^F fits in 20 + F bits
  localparam int KB      = 20 + FRACTION_BITS;
  localparam int RATE_SH = 64 - KB;
  localparam int CNT_W   = 7;

  localparam logic [63:0]           RATE_SCALE = 64'd1000000 << FRACTION_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [CNT_W-1:0]      STEPS_FULL = CNT_W'(64);
  localparam logic [CNT_W-1:0]      STEPS_SQRT = CNT_W'(32);
  localparam logic [CNT_W-1:0]      STEPS_MEAN = CNT_W'(MW);
  localparam logic [CNT_W-1:0]      STEPS_RATE = CNT_W'(KB);
  localparam logic [CNT_W-1:0]      STEP_LAST  = CNT_W'(1);
  localparam logic [1:0]            PKT_STEP_LAST = 2'd3;
  localparam logic [63:0]           SQRT_TOP   = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PKT_PREP,
    ST_STAT_DIV,
    ST_STAT_UPD,
    ST_STAT_MUL,
    ST_STAT_ACC,
    ST_EXP_PREP,
    ST_STD_DIV,
    ST_STD_SQRT,
    ST_RATE_MUL,
    ST_RATE_CHK,
    ST_RATE_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v != COUNT_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [62:0] to_fixed(input logic [63:0] v);
    logic [63:0] lim;
    lim = {1'b0, OUT_MAX} >> FRACTION_BITS;
    if (v > lim) begin
      return OUT_MAX;
    end
    return 63'(v << FRACTION_BITS);
  endfunction

  state_t state;

  // flow record
  logic [COUNT_BITS-1:0] sample_counts [NUM_SETS];
  logic [MW-1:0]         running_means [NUM_SETS];
  logic [63:0]           sq_dev_sums   [NUM_SETS];
  logic [31:0]           min_values    [NUM_SETS];
  logic [31:0]           max_values    [NUM_SETS];
  logic [63:0]           byte_totals   [2];
  logic [TIME_BITS-1:0]  prev_times    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  prev_valid;
  logic [TIME_BITS-1:0]  start_time;
  logic [TIME_BITS-1:0]  latest_time;
  logic [COUNT_BITS-1:0] flag_counts   [NUM_FLAGS];

  // captured input word
  logic [1:0]           pk_func;
  logic                 pk_fwd;
  logic [15:0]          pk_len;
  logic [TIME_BITS-1:0] pk_ts;
  logic [7:0]           pk_flags;

  // sequencer context
  logic [1:0]    pstep;
  logic [2:0]    cur_set;
  logic          cur_ge;
  logic [MW-1:0] cur_d1;
  logic [TIME_BITS-1:0]  exp_dur;
  logic [COUNT_BITS:0]   exp_pk;
  logic [63:0]           exp_bytes;
  logic [5:0]            feat_idx;
  logic [62:0]           out_value;

  // shared unit registers
  logic [63:0]      hreg;
  logic [63:0]      lreg;
  logic [63:0]      qreg;
  logic [63:0]      oreg;
  logic [CNT_W-1:0] cnt;

  // --------------------------------------------------------------------------
  // Input word unpack
  // --------------------------------------------------------------------------
  logic [63:0]          ts_wide;
  logic [TIME_BITS-1:0] ts_in;

  assign ts_wide = {16'b0, s_tdata[64:17]};
  assign ts_in   = ts_wide[TIME_BITS-1:0];

  // --------------------------------------------------------------------------
  // Shared add/subtract unit: one divide, multiply or root bit per cycle
  // --------------------------------------------------------------------------
  unit_op_t    unit_op;
  logic [64:0] ax;
  logic [64:0] ay;
  logic        asub;
  logic [65:0] asum;
  logic [64:0] mul_sel;
  logic [63:0] h_step;
  logic [63:0] l_step;
  logic [63:0] q_step;
  logic        unit_last;
  logic        unit_adv;

  always_comb begin
    case (state)
      ST_STAT_DIV, ST_STD_DIV, ST_RATE_DIV: unit_op = OP_DIV;
      ST_STAT_MUL, ST_RATE_MUL:             unit_op = OP_MUL;
      ST_STD_SQRT:                          unit_op = OP_SQRT;
      default:                              unit_op = OP_IDLE;
    endcase
  end

  always_comb begin
    ax   = {1'b0, hreg};
    ay   = {1'b0, oreg};
    asub = 1'b0;
    case (unit_op)
      OP_DIV: begin
        ax   = {hreg, lreg[63]};
        asub = 1'b1;
      end
      OP_SQRT: begin
        ay   = {1'b0, qreg | lreg};
        asub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign asum = {1'b0, ax} + {1'b0, (asub ? ~ay : ay)} + 66'(asub);

  always_comb begin
    h_step  = hreg;
    l_step  = lreg;
    q_step  = qreg;
    mul_sel = lreg[0] ? asum[64:0] : ax;
    case (unit_op)
      OP_DIV: begin
        // carry out means the shifted remainder covers the divisor
        h_step = asum[65] ? asum[63:0] : ax[63:0];
        l_step = {lreg[62:0], 1'b0};
        q_step = {qreg[62:0], asum[65]};
      end
      OP_MUL: begin
        h_step = mul_sel[64:1];
        l_step = {mul_sel[0], lreg[63:1]};
      end
      OP_SQRT: begin
        h_step = asum[65] ? asum[63:0] : hreg;
        q_step = asum[65] ? ((qreg >> 1) | lreg) : (qreg >> 1);
        l_step = lreg >> 2;
      end
      default: begin
      end
    endcase
  end

  assign unit_last = (cnt == STEP_LAST);
  // the last deviation divide step loads the root operands instead
  assign unit_adv  = (unit_op != OP_IDLE) && !((state == ST_STD_DIV) && unit_last);

  // --------------------------------------------------------------------------
  // Packet step decode: which set, which sample
  // --------------------------------------------------------------------------
  logic [2:0]           st_set;
  logic                 st_is_gap;
  logic [1:0]           gap_slot;
  logic [TIME_BITS-1:0] gap_prev;
  logic [TIME_BITS-1:0] gap_raw;
  logic [63:0]          gap_wide;
  logic [31:0]          st_x;
  logic                 st_run;
  logic [COUNT_BITS-1:0] st_n;
  logic [MW-1:0]        st_big;
  logic [MW-1:0]        st_mean;
  logic                 st_ge;
  logic [MW-1:0]        st_d1;

  always_comb begin
    st_set    = SET_ALL_LEN;
    st_is_gap = 1'b0;
    gap_slot  = SLOT_ALL;
    case (pstep)
      2'd0: st_set = pk_fwd ? SET_FWD_LEN : SET_BWD_LEN;
      2'd1: begin
        st_set    = pk_fwd ? SET_FWD_IAT : SET_BWD_IAT;
        st_is_gap = 1'b1;
        gap_slot  = pk_fwd ? SLOT_FWD : SLOT_BWD;
      end
      2'd2: st_set = SET_ALL_LEN;
      default: begin
        st_set    = SET_ALL_IAT;
        st_is_gap = 1'b1;
        gap_slot  = SLOT_ALL;
      end
    endcase
  end

  assign gap_prev = prev_times[gap_slot];
  // clamp a backward gap to zero and a huge one to the sample range
  assign gap_raw  = (pk_ts >= gap_prev) ? pk_ts - gap_prev : '0;
  assign gap_wide = 64'(gap_raw);
  assign st_x     = st_is_gap ? ((gap_wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : gap_wide[31:0])
                              : {16'b0, pk_len};
  assign st_run   = st_is_gap ? prev_valid[gap_slot] : 1'b1;
  assign st_n     = sat_inc(sample_counts[st_set]);
  assign st_big   = {st_x, {FRACTION_BITS{1'b0}}};
  assign st_mean  = running_means[st_set];
  assign st_ge    = (st_big >= st_mean);
  assign st_d1    = st_ge ? st_big - st_mean : st_mean - st_big;

  // mean update and second deviation once the quotient is in
  logic [MW-1:0]  upd_q;
  logic [MW-1:0]  upd_mean;
  logic [MW-1:0]  upd_d2;
  logic [127:0]   prod_cat;
  logic [63:0]    m2_inc;
  logic [64:0]    m2_sum;

  assign upd_q    = qreg[MW-1:0];
  assign upd_mean = cur_ge ? running_means[cur_set] + upd_q : running_means[cur_set] - upd_q;
  // both signs of the deviation reduce to d1 - q
  assign upd_d2   = cur_d1 - upd_q;
  assign prod_cat = {hreg, lreg};
  assign m2_inc   = 64'(prod_cat >> INC_SH);
  assign m2_sum   = {1'b0, sq_dev_sums[cur_set]} + {1'b0, m2_inc};

  // --------------------------------------------------------------------------
  // Dispatch arithmetic
  // --------------------------------------------------------------------------
  logic        bt_sel;
  logic [64:0] bt_sum;
  logic [TIME_BITS-1:0] dur_now;
  logic [64:0] bytes_sum;

  assign bt_sel    = pk_fwd ? 1'b0 : 1'b1;
  assign bt_sum    = {1'b0, byte_totals[bt_sel]} + 65'(pk_len);
  assign dur_now   = (latest_time >= start_time) ? latest_time - start_time : '0;
  assign bytes_sum = {1'b0, byte_totals[0]} + {1'b0, byte_totals[1]};

  // --------------------------------------------------------------------------
  // Export feature decode
  // --------------------------------------------------------------------------
  logic [5:0]  feat_off;
  logic [2:0]  feat_set;
  logic [1:0]  feat_pos;
  logic [2:0]  flag_sel;
  logic [62:0] direct_val;
  logic        need_std;
  logic        need_rate;
  logic [63:0] rate_total;
  logic [127:0] rate_prod;
  logic [COUNT_BITS-1:0] feat_n;

  assign feat_off   = feat_idx - FEAT_SET1_BASE;
  assign flag_sel   = 3'(feat_idx - FEAT_FLAG_BASE);
  assign rate_total = (feat_idx == FEAT_BYTE_RATE) ? exp_bytes : 64'(exp_pk);
  assign rate_prod  = prod_cat >> RATE_SH;
  assign feat_n     = sample_counts[feat_set];

  always_comb begin
    feat_set   = SET_ALL_LEN;
    feat_pos   = POS_MEAN;
    direct_val = '0;
    need_std   = 1'b0;
    need_rate  = 1'b0;
    case (feat_idx) inside
      [FEAT_SET0_BASE:FEAT_SET0_LAST]: begin
        feat_set = SET_ALL_LEN;
        feat_pos = feat_idx[1:0] - 2'd2;
      end
      [FEAT_SET1_BASE:LAST_FEATURE]: begin
        feat_set = 3'(feat_off[4:2]) + 3'd1;
        feat_pos = feat_off[1:0];
      end
      default: begin
      end
    endcase
    case (feat_idx) inside
      FEAT_DURATION:  direct_val = to_fixed(64'(exp_dur));
      FEAT_FWD_PKTS:  direct_val = to_fixed(64'(sample_counts[SET_FWD_LEN]));
      FEAT_BWD_PKTS:  direct_val = to_fixed(64'(sample_counts[SET_BWD_LEN]));
      FEAT_ALL_PKTS:  direct_val = to_fixed(64'(exp_pk));
      FEAT_FWD_BYTES: direct_val = to_fixed(byte_totals[0]);
      FEAT_BWD_BYTES: direct_val = to_fixed(byte_totals[1]);
      FEAT_BYTE_RATE, FEAT_PKT_RATE: need_rate = (exp_dur != '0);
      [FEAT_FLAG_BASE:FEAT_FLAG_LAST]: direct_val = to_fixed(64'(flag_counts[flag_sel]));
      [FEAT_SET0_BASE:FEAT_SET0_LAST], [FEAT_SET1_BASE:LAST_FEATURE]: begin
        case (feat_pos)
          POS_MEAN: direct_val = 63'(running_means[feat_set]);
          POS_STD:  need_std   = (feat_n > COUNT_BITS'(1));
          POS_MIN:  direct_val = (feat_n != '0) ? to_fixed(64'(min_values[feat_set])) : '0;
          default:  direct_val = to_fixed(64'(max_values[feat_set]));
        endcase
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic clear_now;

  assign clear_now = (state == ST_DISPATCH) && (pk_func == FUNC_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pstep <= 2'd0;
      feat_idx <= '0;
      cnt   <= '0;
    end else begin
      // advance the shared unit by one bit
      if (unit_adv) begin
        hreg <= h_step;
        lreg <= l_step;
        qreg <= q_step;
        cnt  <= cnt - STEP_LAST;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pk_func  <= s_tuser[1:0];
            pk_fwd   <= s_tdata[0];
            pk_len   <= s_tdata[16:1];
            pk_ts    <= ts_in;
            pk_flags <= s_tdata[72:65];
            state    <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          case (pk_func)
            FUNC_UPDATE: begin
              if (!prev_valid[SLOT_ALL]) begin
                start_time <= pk_ts;
              end
              latest_time <= pk_ts;
              byte_totals[bt_sel] <= bt_sum[64] ? '1 : bt_sum[63:0];
              for (int i = 0; i < NUM_FLAGS; i++) begin
                if (pk_flags[FLAG_POS[i]]) begin
                  flag_counts[i] <= sat_inc(flag_counts[i]);
                end
              end
              pstep <= 2'd0;
              state <= ST_PKT_PREP;
            end
            FUNC_EXPORT: begin
              exp_dur   <= dur_now;
              exp_pk    <= {1'b0, sample_counts[SET_FWD_LEN]}
                         + {1'b0, sample_counts[SET_BWD_LEN]};
              exp_bytes <= bytes_sum[64] ? '1 : bytes_sum[63:0];
              feat_idx  <= FEAT_DURATION;
              state     <= ST_EXP_PREP;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_PKT_PREP: begin
          if (st_is_gap) begin
            prev_times[gap_slot] <= pk_ts;
            prev_valid[gap_slot] <= 1'b1;
          end
          if (st_run) begin
            sample_counts[st_set] <= st_n;
            if (st_x < min_values[st_set]) begin
              min_values[st_set] <= st_x;
            end
            if (st_x > max_values[st_set]) begin
              max_values[st_set] <= st_x;
            end
            cur_set <= st_set;
            cur_ge  <= st_ge;
            cur_d1  <= st_d1;
            // left-align the deviation so only its own bits are stepped
            hreg    <= '0;
            lreg    <= {st_d1, {MPAD{1'b0}}};
            qreg    <= '0;
            oreg    <= 64'(st_n);
            cnt     <= STEPS_MEAN;
            state   <= ST_STAT_DIV;
          end else if (pstep == PKT_STEP_LAST) begin
            state <= ST_IDLE;
          end else begin
            pstep <= pstep + 2'd1;
          end
        end
        ST_STAT_DIV: begin
          if (unit_last) begin
            state <= ST_STAT_UPD;
          end
        end
        ST_STAT_UPD: begin
          running_means[cur_set] <= upd_mean;
          hreg  <= '0;
          lreg  <= 64'(upd_d2);
          oreg  <= 64'(cur_d1);
          cnt   <= STEPS_MEAN;
          state <= ST_STAT_MUL;
        end
        ST_STAT_MUL: begin
          if (unit_last) begin
            state <= ST_STAT_ACC;
          end
        end
        ST_STAT_ACC: begin
          sq_dev_sums[cur_set] <= m2_sum[64] ? '1 : m2_sum[63:0];
          if (pstep == PKT_STEP_LAST) begin
            state <= ST_IDLE;
          end else begin
            pstep <= pstep + 2'd1;
            state <= ST_PKT_PREP;
          end
        end
        ST_EXP_PREP: begin
          if (need_std) begin
            hreg  <= '0;
            lreg  <= sq_dev_sums[feat_set];
            qreg  <= '0;
            oreg  <= 64'(feat_n);
            cnt   <= STEPS_FULL;
            state <= ST_STD_DIV;
          end else if (need_rate) begin
            hreg  <= '0;
            lreg  <= RATE_SCALE;
            oreg  <= rate_total;
            cnt   <= STEPS_RATE;
            state <= ST_RATE_MUL;
          end else begin
            out_value <= direct_val;
            state     <= ST_EMIT;
          end
        end
        ST_STD_DIV: begin
          // hand the quotient straight to the root
          if (unit_last) begin
            hreg  <= q_step;
            qreg  <= '0;
            lreg  <= SQRT_TOP;
            cnt   <= STEPS_SQRT;
            state <= ST_STD_SQRT;
          end
        end
        ST_STD_SQRT: begin
          if (unit_last) begin
            out_value <= 63'(64'(q_step[31:0]) << FRACTION_BITS);
            state     <= ST_EMIT;
          end
        end
        ST_RATE_MUL: begin
          if (unit_last) begin
            state <= ST_RATE_CHK;
          end
        end
        ST_RATE_CHK: begin
          // a high half at or above the divisor overflows the quotient
          if (rate_prod[127:64] >= 64'(exp_dur)) begin
            out_value <= OUT_MAX;
            state     <= ST_EMIT;
          end else begin
            hreg  <= rate_prod[127:64];
            lreg  <= rate_prod[63:0];
            qreg  <= '0;
            oreg  <= 64'(exp_dur);
            cnt   <= STEPS_FULL;
            state <= ST_RATE_DIV;
          end
        end
        ST_RATE_DIV: begin
          if (unit_last) begin
            out_value <= q_step[63] ? OUT_MAX : q_step[62:0];
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (feat_idx == LAST_FEATURE) begin
              state <= ST_IDLE;
            end else begin
              feat_idx <= feat_idx + 6'd1;
              state    <= ST_EXP_PREP;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    // return the record to its empty state
    if (rst || clear_now) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        sample_counts[i] <= '0;
        running_means[i] <= '0;
        sq_dev_sums[i]   <= '0;
        min_values[i]    <= '1;
        max_values[i]    <= '0;
        flag_counts[i]   <= '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        prev_times[i] <= '0;
      end
      prev_valid     <= '0;
      byte_totals[0] <= '0;
      byte_totals[1] <= '0;
      start_time     <= '0;
      latest_time    <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = {3'b0, out_value, feat_idx};
  assign m_tlast  = (feat_idx == LAST_FEATURE);

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `FFA_ASSERT_IMPL(a_no_take_while_emit, clk, rst, m_tvalid, !s_tready)
  `FFA_ASSERT_NEXT(a_take_goes_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  `FFA_ASSERT_NEXT(a_run_ends_on_last, clk, rst, m_tvalid && m_tready && !m_tlast, !s_tready)
  `FFA_ASSERT_IMPL(a_unit_has_steps, clk, rst, unit_op != OP_IDLE, cnt != '0)

endmodule
